// ===== src/emg_pkg.sv =====
`timescale 1ns / 1ps

package emg_pkg;

  // Height codes that mark a void sample (-32768 and -9999).
  localparam logic [15:0] VOID_PRIMARY   = 16'h8000;
  localparam logic [15:0] VOID_ALTERNATE = 16'hD8F1;

  // Reset values of the running extremes.
  localparam logic signed [15:0] MIN_RESET = 16'sh7FFF;
  localparam logic signed [15:0] MAX_RESET = 16'sh8000;

  localparam logic [7:0] GRAY_ZERO = 8'h00;
  localparam logic [7:0] GRAY_FULL = 8'hFF;

  // How the back end settles a pixel.
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  // One classified scale request on its way from the front to the back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] off;
    logic [15:0] diff;
    logic        void_flag;
    logic        last;
  } emg_entry_t;

endpackage

// ===== src/emg_front.sv =====
`timescale 1ns / 1ps

module emg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                swap_bytes_we,
  input  logic                swap_bytes_wdata,
  input  logic                push,
  input  logic                full,
  input  logic                action,
  input  logic [15:0]         height_word,
  input  logic                last_sample,
  output logic                q_push,
  output emg_pkg::emg_entry_t q_entry
);

  logic                swap_bytes;
  logic signed [15:0]  min_height;
  logic signed [15:0]  max_height;
  logic                accept;
  logic signed [15:0]  height;
  logic                is_void;
  logic signed [16:0]  diff;
  logic signed [16:0]  off;
  logic                diff_pos;
  logic                off_pos;
  logic                off_ge;

  assign accept = push && !full;
  assign q_push = accept && action;

  // Byte order correction and void detection.
  assign height  = swap_bytes ? {height_word[7:0], height_word[15:8]} : height_word;
  assign is_void = (height == emg_pkg::VOID_PRIMARY) || (height == emg_pkg::VOID_ALTERNATE);

  // Range and offset against the extremes measured so far.
  assign diff     = {max_height[15], max_height} - {min_height[15], min_height};
  assign off      = {height[15], height} - {min_height[15], min_height};
  assign diff_pos = !diff[16] && (diff != 17'sd0);
  assign off_pos  = !off[16] && (off != 17'sd0);
  assign off_ge   = off >= diff;

  // Classify the request so that only strictly interior values reach the divider.
  always_comb begin
    q_entry.off       = off[15:0];
    q_entry.diff      = diff[15:0];
    q_entry.void_flag = is_void;
    q_entry.last      = last_sample;
    if (!diff_pos) begin
      q_entry.mode = emg_pkg::MODE_ZERO;
    end else if (is_void) begin
      q_entry.mode = emg_pkg::MODE_FULL;
    end else if (!off_pos) begin
      q_entry.mode = emg_pkg::MODE_ZERO;
    end else if (off_ge) begin
      q_entry.mode = emg_pkg::MODE_FULL;
    end else begin
      q_entry.mode = emg_pkg::MODE_DIV;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_bytes <= 1'b1;
    end else if (swap_bytes_we) begin
      swap_bytes <= swap_bytes_wdata;
    end
  end

  // Running extremes: measure requests widen them, the last scale request clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_height <= emg_pkg::MIN_RESET;
      max_height <= emg_pkg::MAX_RESET;
    end else if (accept && action && last_sample) begin
      min_height <= emg_pkg::MIN_RESET;
      max_height <= emg_pkg::MAX_RESET;
    end else if (accept && !action && !is_void) begin
      if (height < min_height) begin
        min_height <= height;
      end
      if (height > max_height) begin
        max_height <= height;
      end
    end
  end

`ifndef SYNTHESIS
  // The final scale request of a grid leaves the extremes at their reset values.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && action && last_sample) |=>
      (min_height == emg_pkg::MIN_RESET) && (max_height == emg_pkg::MAX_RESET))
    else $error("extremes not cleared after last scale request");
`endif

endmodule

// ===== src/emg_queue.sv =====
`timescale 1ns / 1ps

module emg_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  emg_pkg::emg_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output emg_pkg::emg_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  emg_pkg::emg_entry_t slots [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The front end must never offer a request while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  // Pointers stay consistent with the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_FULL) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== src/emg_back.sv =====
`timescale 1ns / 1ps

module emg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  emg_pkg::emg_entry_t q_head,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          gray,
  output logic                void_pixel,
  output logic                last_pixel
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]  state;
  logic [15:0] rem;
  logic [7:0]  nlow;
  logic [7:0]  quot;
  logic [2:0]  cnt;
  logic [15:0] diff_r;
  logic [7:0]  pend_gray;
  logic        pend_void;
  logic        pend_last;
  logic        out_valid;
  logic [23:0] num;
  logic [16:0] trial;
  logic [16:0] trial_sub;
  logic        ge;
  logic [15:0] rem_next;
  logic        load_out;
  logic        pop_ok;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign empty    = !out_valid;
  assign pop_ok   = pop && out_valid;
  assign load_out = (state == ST_WAIT) && (!out_valid || pop);

  // Numerator off*255 as a shift and subtract.
  assign num = {q_head.off, 8'h00} - {8'h00, q_head.off};

  // One restoring division step per cycle.
  assign trial     = {rem, nlow[7]};
  assign ge        = trial >= {1'b0, diff_r};
  assign trial_sub = trial - {1'b0, diff_r};
  assign rem_next  = ge ? trial_sub[15:0] : trial[15:0];

  // Sequencer: take a request, divide if needed, hand the pixel to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pend_void <= q_head.void_flag;
            pend_last <= q_head.last;
            diff_r    <= q_head.diff;
            rem       <= num[23:8];
            nlow      <= num[7:0];
            quot      <= '0;
            cnt       <= 3'd7;
            if (q_head.mode == emg_pkg::MODE_DIV) begin
              state <= ST_DIV;
            end else begin
              pend_gray <= (q_head.mode == emg_pkg::MODE_FULL) ? emg_pkg::GRAY_FULL
                                                                : emg_pkg::GRAY_ZERO;
              state     <= ST_WAIT;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          nlow <= {nlow[6:0], 1'b0};
          quot <= {quot[6:0], ge};
          cnt  <= cnt - 1'b1;
          if (cnt == 3'd0) begin
            pend_gray <= {quot[6:0], ge};
            state     <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a finished pixel waits here while the next request is fetched.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop_ok) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gray       <= pend_gray;
      void_pixel <= pend_void;
      last_pixel <= pend_last;
    end
  end

`ifndef SYNTHESIS
  // The partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < diff_r))
    else $error("division remainder out of range");

  // A pending pixel with a free output register is shown in the next cycle.
  a_handover: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("pending pixel not handed over");

  // Requests are only taken from the queue between pixels.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE))
    else $error("queue popped while busy");
`endif

endmodule

// ===== src/elevation_minmax_to_gray_unit.sv =====
`timescale 1ns / 1ps

// Min-max normaliser from 16-bit elevation words to 8-bit gray. Stream the grid once with
// action low to measure the extremes (no pixel comes out), then again with action high to
// get one pixel per sample; the scale sample marked last clears the extremes for the next
// grid. Measure samples are taken one per clock unless the queue is full. Scale samples
// are classified in the front end and pass through a queue of QUEUE_DEPTH entries to a
// back end that settles one pixel at a time: void, clipped and empty-range pixels are set
// directly, interior values go through the restoring divider, one quotient bit per cycle;
// the back end sets the sustained scale rate, and the queue lets measure samples and
// short bursts continue while it works. swap_bytes may be written only while no pixel is outstanding.

module elevation_minmax_to_gray_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        swap_bytes_we,
  input  logic        swap_bytes_wdata,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [15:0] height_word,
  input  logic        last_sample,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  gray,
  output logic        void_pixel,
  output logic        last_pixel
);

  logic                q_push;
  emg_pkg::emg_entry_t q_entry;
  logic                q_pop;
  logic                q_valid;
  emg_pkg::emg_entry_t q_head;

  // Front end: byte order, void check, extremes and classification.
  emg_front u_front (
    .clk              (clk),
    .rst              (rst),
    .swap_bytes_we    (swap_bytes_we),
    .swap_bytes_wdata (swap_bytes_wdata),
    .push             (push),
    .full             (full),
    .action           (action),
    .height_word      (height_word),
    .last_sample      (last_sample),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  // Queue of classified scale requests.
  emg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Back end: divider and output register.
  emg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .gray       (gray),
    .void_pixel (void_pixel),
    .last_pixel (last_pixel)
  );

endmodule
